// File: rtl/core/clock_alarm_countdown_display_assert.svh
// Assertion macros shared by the clock/alarm/countdown display RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CLOCK_ALARM_COUNTDOWN_DISPLAY_ASSERT_SVH
`define CLOCK_ALARM_COUNTDOWN_DISPLAY_ASSERT_SVH
`ifndef SYNTHESIS
`define CACD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CACD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CACD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CACD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/cacd_pkg.sv
// Package for the clock/alarm/countdown display: constants, codes, structs, digit split.
// No dependencies; used by cacd_state, cacd_div, cacd_fmt, the top level and the testbench.
`default_nettype none
package cacd_pkg;

    localparam int RING_PERIOD_MS = 10000;
    localparam int RING_PULSE_MS  = 100;
    localparam int RING_W         = $clog2(RING_PERIOD_MS);

    localparam int MS_PER_SEC     = 1000;
    localparam int SEC_PER_MIN    = 60;
    localparam int SEC_PER_HOUR   = 3600;
    localparam int HALF_DAY       = 12;
    localparam int MAX_HOUR       = 23;
    localparam int MAX_MIN_SEC    = 59;
    localparam int DEC_BASE       = 10;
    localparam int MAX_SHOWN_HOUR = 99;

    localparam logic [28:0] MAX_COUNTDOWN = 29'd359999999;
    localparam int          MAX_SECS      = 359999;
    localparam logic [3:0]  BLANK_DIGIT   = 4'd10;

    // reciprocal constants: x/1000 = (x>>3)/125, s/3600 = (s>>4)/225, r/60 = (r>>2)/15
    localparam logic [26:0] RECIP_125    = 27'd68719477;
    localparam int          RECIP_125_SH = 33;
    localparam logic [15:0] RECIP_225    = 16'd37283;
    localparam int          RECIP_225_SH = 23;
    localparam logic [10:0] RECIP_15     = 11'd1093;
    localparam int          RECIP_15_SH  = 14;

    localparam int PIPE_DEPTH = 5;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SET_TIME,
        OP_START,
        OP_SILENCE
    } t_opcode;

    typedef enum logic [2:0] {
        REG_HOUR_24_MODE,
        REG_SHOW_LEADING_ZERO,
        REG_ALARM_HOUR,
        REG_ALARM_MINUTE,
        REG_ALARM_SECOND,
        REG_DAY_START_HOUR,
        REG_DAY_END_HOUR,
        REG_SHOW_TIMER
    } t_reg_idx;

    typedef struct packed {
        t_opcode     opcode;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
        logic [5:0]  new_second;
        logic [28:0] countdown_ms;
    } t_req;

    typedef struct packed {
        logic        timer_mode;
        logic [4:0]  clk_hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        blank_lead;
        logic [28:0] rem;
        logic        night;
        logic [9:0]  millis;
        logic        sound;
        logic        alarm;
    } t_snap;

    typedef struct packed {
        t_snap       snap;
        logic [18:0] secs;
        logic [6:0]  hours;
        logic [11:0] rs;
        logic [5:0]  mins;
    } t_work;

    typedef struct packed {
        logic [3:0] d0;
        logic [3:0] d1;
        logic [3:0] d2;
        logic [3:0] d3;
        logic [3:0] d4;
        logic [3:0] d5;
        logic       night;
        logic [9:0] millis;
        logic       sound;
        logic       alarm;
    } t_disp;

    // tens and units of a value below 100
    function automatic logic [7:0] split2(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] units;
        tens = '0;
        for (int k = 1; k < DEC_BASE; k++) begin
            if (v >= 7'(k * DEC_BASE)) begin
                tens = 4'(k);
            end
        end
        units = v - 7'(tens) * 7'(DEC_BASE);
        return {tens, units[3:0]};
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/cacd_req_if.sv
// Request channel interface: valid/ready handshake plus the input fields.
// Depends on nothing.
`default_nettype none
interface cacd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [5:0]  new_second;
    logic [28:0] countdown_ms;

    modport source (output valid, output opcode, output new_hour, output new_minute,
                    output new_second, output countdown_ms, input ready);
    modport sink   (input valid, input opcode, input new_hour, input new_minute,
                    input new_second, input countdown_ms, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cacd_res_if.sv
// Result channel interface: valid/ready handshake plus the display fields.
// Depends on nothing.
`default_nettype none
interface cacd_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit0;
    logic [3:0] digit1;
    logic [3:0] digit2;
    logic [3:0] digit3;
    logic [3:0] digit4;
    logic [3:0] digit5;
    logic       night_flag;
    logic [9:0] millis_part;
    logic       sound;
    logic       alarm_playing;

    modport source (output valid, output digit0, output digit1, output digit2, output digit3,
                    output digit4, output digit5, output night_flag, output millis_part,
                    output sound, output alarm_playing, input ready);
    modport sink   (input valid, input digit0, input digit1, input digit2, input digit3,
                    input digit4, input digit5, input night_flag, input millis_part,
                    input sound, input alarm_playing, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cacd_state.sv
// Configuration registers, time-of-day / alarm / countdown state and its per-request update.
// Depends on cacd_pkg and the assertion macro header.
`default_nettype none
`include "clock_alarm_countdown_display_assert.svh"
module cacd_state (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [5:0]     i_cfg_data,
    input  wire logic           i_acc,
    input  wire cacd_pkg::t_req i_req,
    output cacd_pkg::t_snap     o_snap
);

    logic       r_h24, r_lead, r_timer;
    logic [4:0] r_al_h, r_day_s, r_day_e;
    logic [5:0] r_al_m, r_al_s;

    logic [4:0]                  r_hour, n_hour;
    logic [5:0]                  r_minute, n_minute;
    logic [5:0]                  r_second, n_second;
    logic [9:0]                  r_millis, n_millis;
    logic                        r_set, n_set;
    logic                        r_alarm, n_alarm;
    logic                        r_running, n_running;
    logic [28:0]                 r_rem, n_rem;
    logic [cacd_pkg::RING_W-1:0] r_phase, n_phase;

    logic       pulse;
    logic [4:0] shown_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h24   <= 1'b1;
            r_lead  <= 1'b1;
            r_al_h  <= 5'd7;
            r_al_m  <= '0;
            r_al_s  <= '0;
            r_day_s <= 5'd6;
            r_day_e <= 5'd18;
            r_timer <= 1'b0;
        end else if (i_cfg_we) begin
            case (cacd_pkg::t_reg_idx'(i_cfg_idx))
                cacd_pkg::REG_HOUR_24_MODE:      r_h24   <= i_cfg_data[0];
                cacd_pkg::REG_SHOW_LEADING_ZERO: r_lead  <= i_cfg_data[0];
                cacd_pkg::REG_ALARM_HOUR:        r_al_h  <= i_cfg_data[4:0];
                cacd_pkg::REG_ALARM_MINUTE:      r_al_m  <= i_cfg_data;
                cacd_pkg::REG_ALARM_SECOND:      r_al_s  <= i_cfg_data;
                cacd_pkg::REG_DAY_START_HOUR:    r_day_s <= i_cfg_data[4:0];
                cacd_pkg::REG_DAY_END_HOUR:      r_day_e <= i_cfg_data[4:0];
                cacd_pkg::REG_SHOW_TIMER:        r_timer <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_second  = r_second;
        n_millis  = r_millis;
        n_set     = r_set;
        n_alarm   = r_alarm;
        n_running = r_running;
        n_rem     = r_rem;
        n_phase   = r_phase;
        case (i_req.opcode)
            cacd_pkg::OP_TICK: begin
                if (r_millis == 10'(cacd_pkg::MS_PER_SEC - 1)) begin
                    n_millis = '0;
                    if (r_second == 6'(cacd_pkg::MAX_MIN_SEC)) begin
                        n_second = '0;
                        if (r_minute == 6'(cacd_pkg::MAX_MIN_SEC)) begin
                            n_minute = '0;
                            n_hour   = (r_hour >= 5'(cacd_pkg::MAX_HOUR)) ? '0 : r_hour + 5'd1;
                        end else begin
                            n_minute = r_minute + 6'd1;
                        end
                    end else begin
                        n_second = r_second + 6'd1;
                    end
                end else begin
                    n_millis = r_millis + 10'd1;
                end
                if (r_alarm || (r_running && r_rem == '0)) begin
                    n_phase = (r_phase == cacd_pkg::RING_W'(cacd_pkg::RING_PERIOD_MS - 1)) ?
                              '0 : r_phase + cacd_pkg::RING_W'(1);
                end
                if (r_rem != '0) begin
                    n_rem = r_rem - 29'd1;
                end
                if (!r_timer && !r_alarm && n_hour == r_al_h && n_minute == r_al_m &&
                    n_second == r_al_s) begin
                    n_alarm = 1'b1;
                    n_phase = '0;
                end
            end
            cacd_pkg::OP_SET_TIME: begin
                n_hour   = (i_req.new_hour > 5'(cacd_pkg::MAX_HOUR)) ?
                           5'(cacd_pkg::MAX_HOUR) : i_req.new_hour;
                n_minute = (i_req.new_minute > 6'(cacd_pkg::MAX_MIN_SEC)) ?
                           6'(cacd_pkg::MAX_MIN_SEC) : i_req.new_minute;
                n_second = (i_req.new_second > 6'(cacd_pkg::MAX_MIN_SEC)) ?
                           6'(cacd_pkg::MAX_MIN_SEC) : i_req.new_second;
                n_millis = '0;
                n_set    = 1'b1;
            end
            cacd_pkg::OP_START: begin
                n_rem     = (i_req.countdown_ms > cacd_pkg::MAX_COUNTDOWN) ?
                            cacd_pkg::MAX_COUNTDOWN : i_req.countdown_ms;
                n_running = 1'b1;
                n_phase   = '0;
            end
            cacd_pkg::OP_SILENCE: begin
                n_alarm   = 1'b0;
                n_running = 1'b0;
            end
            default: ;
        endcase

        pulse = n_phase < cacd_pkg::RING_W'(cacd_pkg::RING_PULSE_MS);
        if (!r_h24 && n_hour > 5'(cacd_pkg::HALF_DAY)) begin
            shown_h = n_hour - 5'(cacd_pkg::HALF_DAY);
        end else if (!r_h24 && n_hour == '0 && n_set) begin
            shown_h = 5'(cacd_pkg::HALF_DAY);
        end else begin
            shown_h = n_hour;
        end

        o_snap.timer_mode = r_timer;
        o_snap.clk_hour   = shown_h;
        o_snap.minute     = n_minute;
        o_snap.second     = n_second;
        o_snap.blank_lead = !r_lead && shown_h < 5'(cacd_pkg::DEC_BASE) && n_set;
        o_snap.rem        = n_rem;
        o_snap.night      = !(n_hour >= r_day_s && n_hour <= r_day_e);
        o_snap.millis     = n_millis;
        o_snap.sound      = r_timer ? (n_running && n_rem == '0 && pulse) : (n_alarm && pulse);
        o_snap.alarm      = n_alarm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour    <= '0;
            r_minute  <= '0;
            r_second  <= '0;
            r_millis  <= '0;
            r_set     <= 1'b0;
            r_alarm   <= 1'b0;
            r_running <= 1'b0;
            r_rem     <= '0;
            r_phase   <= '0;
        end else if (i_acc) begin
            r_hour    <= n_hour;
            r_minute  <= n_minute;
            r_second  <= n_second;
            r_millis  <= n_millis;
            r_set     <= n_set;
            r_alarm   <= n_alarm;
            r_running <= n_running;
            r_rem     <= n_rem;
            r_phase   <= n_phase;
        end
    end

    `CACD_ASSERT(a_phase_range, i_clk, i_rst_n, r_phase < cacd_pkg::RING_W'(cacd_pkg::RING_PERIOD_MS), "ring phase out of range")
    `CACD_ASSERT(a_rem_range, i_clk, i_rst_n, r_rem <= cacd_pkg::MAX_COUNTDOWN, "countdown above limit")
    `CACD_ASSERT(a_time_range, i_clk, i_rst_n, r_hour <= 5'(cacd_pkg::MAX_HOUR) && r_minute <= 6'(cacd_pkg::MAX_MIN_SEC) && r_second <= 6'(cacd_pkg::MAX_MIN_SEC) && r_millis < 10'(cacd_pkg::MS_PER_SEC), "time of day out of range")

endmodule
`default_nettype wire

// File: rtl/core/cacd_div.sv
// Pipelined split of the remaining countdown into hours, minutes and seconds.
// Reciprocal multiplies for the /1000, /3600 and /60 steps; depends on cacd_pkg and the assertion macro header.
`default_nettype none
`include "clock_alarm_countdown_display_assert.svh"
module cacd_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire cacd_pkg::t_snap i_snap,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output cacd_pkg::t_work      o_work
);

    logic            r_v [cacd_pkg::PIPE_DEPTH];
    cacd_pkg::t_work r_p [cacd_pkg::PIPE_DEPTH];
    cacd_pkg::t_work n_p [cacd_pkg::PIPE_DEPTH];
    logic            in_v [cacd_pkg::PIPE_DEPTH];
    logic            stage_rdy [cacd_pkg::PIPE_DEPTH];

    logic [52:0] prod1;
    logic [30:0] prod2;
    logic [20:0] prod3;

    always_comb begin
        stage_rdy[cacd_pkg::PIPE_DEPTH-1] = !r_v[cacd_pkg::PIPE_DEPTH-1] || i_ready;
        for (int k = cacd_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_v[k] || stage_rdy[k+1];
        end
        in_v[0] = i_valid;
        for (int k = 1; k < cacd_pkg::PIPE_DEPTH; k++) begin
            in_v[k] = r_v[k-1];
        end

        n_p[0]      = '0;
        n_p[0].snap = i_snap;

        prod1       = 53'(r_p[0].snap.rem[28:3]) * 53'(cacd_pkg::RECIP_125);
        n_p[1]      = r_p[0];
        n_p[1].secs = 19'(prod1 >> cacd_pkg::RECIP_125_SH);

        prod2        = 31'(r_p[1].secs[18:4]) * 31'(cacd_pkg::RECIP_225);
        n_p[2]       = r_p[1];
        n_p[2].hours = 7'(prod2 >> cacd_pkg::RECIP_225_SH);

        n_p[3]    = r_p[2];
        n_p[3].rs = 12'(r_p[2].secs - 19'(r_p[2].hours) * 19'(cacd_pkg::SEC_PER_HOUR));

        prod3       = 21'(r_p[3].rs[11:2]) * 21'(cacd_pkg::RECIP_15);
        n_p[4]      = r_p[3];
        n_p[4].mins = 6'(prod3 >> cacd_pkg::RECIP_15_SH);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cacd_pkg::PIPE_DEPTH; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (stage_rdy[k]) begin
                r_v[k] <= in_v[k];
            end
            if (stage_rdy[k] && in_v[k]) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    assign o_ready = stage_rdy[0];
    assign o_valid = r_v[cacd_pkg::PIPE_DEPTH-1];
    assign o_work  = r_p[cacd_pkg::PIPE_DEPTH-1];

    `CACD_ASSERT_IMPL(a_secs_range, i_clk, i_rst_n, r_v[1], r_p[1].secs <= 19'(cacd_pkg::MAX_SECS), "seconds quotient too large")
    `CACD_ASSERT_IMPL(a_hours_range, i_clk, i_rst_n, r_v[2], r_p[2].hours <= 7'(cacd_pkg::MAX_SHOWN_HOUR), "hours quotient too large")
    `CACD_ASSERT_IMPL(a_split_range, i_clk, i_rst_n, r_v[4], r_p[4].rs < 12'(cacd_pkg::SEC_PER_HOUR) && r_p[4].mins <= 6'(cacd_pkg::MAX_MIN_SEC), "minute split out of range")

endmodule
`default_nettype wire

// File: rtl/core/cacd_fmt.sv
// Display formatting: final seconds remainder, decimal digit split and mode select.
// Combinational; depends on cacd_pkg.
`default_nettype none
module cacd_fmt (
    input  wire cacd_pkg::t_work i_work,
    output cacd_pkg::t_disp      o_disp
);

    logic [5:0] ss;
    logic [7:0] hp, mp, sp;

    always_comb begin
        ss = 6'(i_work.rs - 12'(i_work.mins) * 12'(cacd_pkg::SEC_PER_MIN));
        if (i_work.snap.timer_mode) begin
            hp = cacd_pkg::split2(i_work.hours);
            mp = cacd_pkg::split2(7'(i_work.mins));
            sp = cacd_pkg::split2(7'(ss));
        end else begin
            hp = cacd_pkg::split2(7'(i_work.snap.clk_hour));
            mp = cacd_pkg::split2(7'(i_work.snap.minute));
            sp = cacd_pkg::split2(7'(i_work.snap.second));
        end
        o_disp.d0     = (!i_work.snap.timer_mode && i_work.snap.blank_lead) ?
                        cacd_pkg::BLANK_DIGIT : hp[7:4];
        o_disp.d1     = hp[3:0];
        o_disp.d2     = mp[7:4];
        o_disp.d3     = mp[3:0];
        o_disp.d4     = sp[7:4];
        o_disp.d5     = sp[3:0];
        o_disp.night  = i_work.snap.night;
        o_disp.millis = i_work.snap.millis;
        o_disp.sound  = i_work.snap.sound;
        o_disp.alarm  = i_work.snap.alarm;
    end

endmodule
`default_nettype wire

// File: rtl/core/clock_alarm_countdown_display.sv
// Top level of the millisecond clock with alarm and countdown timer display.
// Uses cacd_pkg, cacd_req_if, cacd_res_if, cacd_state, cacd_div and cacd_fmt.
//
// One request per clock is taken (tick, set time, start countdown, silence) while the
// first stage is ready, and each gives one display result. The state update happens
// at the accepting edge; the result then passes a five-stage chain (snapshot, /1000,
// /3600, remainder, /60) and an output register, with per-stage handshaking, so up
// to six results can be in flight and requests keep flowing while a result waits at
// the output, until every stage is full.
`default_nettype none
module clock_alarm_countdown_display (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    cacd_req_if.sink        i_req,
    cacd_res_if.source      o_res,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [5:0] i_cfg_data
);

    cacd_pkg::t_req  req;
    cacd_pkg::t_snap snap;
    cacd_pkg::t_work work;
    cacd_pkg::t_disp disp;
    cacd_pkg::t_disp r_disp;
    logic            r_ov;
    logic            acc;
    logic            div_ready, div_valid, out_rdy;

    assign req.opcode       = cacd_pkg::t_opcode'(i_req.opcode);
    assign req.new_hour     = i_req.new_hour;
    assign req.new_minute   = i_req.new_minute;
    assign req.new_second   = i_req.new_second;
    assign req.countdown_ms = i_req.countdown_ms;

    assign i_req.ready = div_ready;
    assign acc         = i_req.valid && div_ready;

    cacd_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_req      (req),
        .o_snap     (snap)
    );

    cacd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (div_ready),
        .i_snap  (snap),
        .o_valid (div_valid),
        .i_ready (out_rdy),
        .o_work  (work)
    );

    cacd_fmt u_fmt (
        .i_work (work),
        .o_disp (disp)
    );

    assign out_rdy = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= div_valid;
        end
        if (out_rdy && div_valid) begin
            r_disp <= disp;
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.digit0        = r_disp.d0;
    assign o_res.digit1        = r_disp.d1;
    assign o_res.digit2        = r_disp.d2;
    assign o_res.digit3        = r_disp.d3;
    assign o_res.digit4        = r_disp.d4;
    assign o_res.digit5        = r_disp.d5;
    assign o_res.night_flag    = r_disp.night;
    assign o_res.millis_part   = r_disp.millis;
    assign o_res.sound         = r_disp.sound;
    assign o_res.alarm_playing = r_disp.alarm;

endmodule
`default_nettype wire

// File: tb/sv/clock_alarm_countdown_display_tb.sv
// Testbench for clock_alarm_countdown_display: drives ticks, set-time, countdown and silence
// requests across several register settings and checks every display result in order.
// Depends on cacd_pkg, cacd_req_if, cacd_res_if and the block itself.
module clock_alarm_countdown_display_tb;
    import cacd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    // Tracks clock, alarm and countdown state and queues the display each request should give.
    class display_scoreboard;
        logic        hour_24, lead_zero, timer_view;
        logic [4:0]  alarm_h, day_first, day_last;
        logic [5:0]  alarm_m, alarm_s;
        logic [4:0]  clk_hour;
        logic [5:0]  clk_min, clk_sec;
        logic [9:0]  clk_ms;
        logic        time_set, ringing, counting;
        logic [28:0] remain;
        logic [13:0] ring_pos;
        t_disp       due_displays[$];
        int          mismatches;
        int          displays_seen;

        function new();
            hour_24 = 1'b1; lead_zero = 1'b1; timer_view = 1'b0;
            alarm_h = 5'd7; alarm_m = '0; alarm_s = '0;
            day_first = 5'd6; day_last = 5'd18;
            clk_hour = '0; clk_min = '0; clk_sec = '0; clk_ms = '0;
            time_set = 1'b0; ringing = 1'b0; counting = 1'b0;
            remain = '0; ring_pos = '0;
            mismatches = 0; displays_seen = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [5:0] v);
            case (idx)
                REG_HOUR_24_MODE:      hour_24 = v[0];
                REG_SHOW_LEADING_ZERO: lead_zero = v[0];
                REG_ALARM_HOUR:        alarm_h = v[4:0];
                REG_ALARM_MINUTE:      alarm_m = v;
                REG_ALARM_SECOND:      alarm_s = v;
                REG_DAY_START_HOUR:    day_first = v[4:0];
                REG_DAY_END_HOUR:      day_last = v[4:0];
                REG_SHOW_TIMER:        timer_view = v[0];
                default: ;
            endcase
        endfunction

        function void take_request(t_req r);
            t_disp       d;
            int unsigned total_s, hh, mm, ss;
            logic        pulse;
            case (r.opcode)
                OP_TICK: begin
                    clk_ms = clk_ms + 1'b1;
                    if (clk_ms == 10'(MS_PER_SEC)) begin
                        clk_ms = '0;
                        clk_sec = clk_sec + 1'b1;
                        if (clk_sec == 6'(SEC_PER_MIN)) begin
                            clk_sec = '0;
                            clk_min = clk_min + 1'b1;
                            if (clk_min == 6'(SEC_PER_MIN)) begin
                                clk_min = '0;
                                clk_hour = (clk_hour >= 5'(MAX_HOUR)) ? '0 : clk_hour + 1'b1;
                            end
                        end
                    end
                    if (ringing || (counting && remain == '0))
                        ring_pos = 14'((int'(ring_pos) + 1) % RING_PERIOD_MS);
                    if (remain != '0) remain = remain - 1'b1;
                    if (!timer_view && !ringing && clk_hour == alarm_h &&
                        clk_min == alarm_m && clk_sec == alarm_s) begin
                        ringing = 1'b1;
                        ring_pos = '0;
                    end
                end
                OP_SET_TIME: begin
                    clk_hour = (r.new_hour > 5'(MAX_HOUR)) ? 5'(MAX_HOUR) : r.new_hour;
                    clk_min = (r.new_minute > 6'(MAX_MIN_SEC)) ? 6'(MAX_MIN_SEC) : r.new_minute;
                    clk_sec = (r.new_second > 6'(MAX_MIN_SEC)) ? 6'(MAX_MIN_SEC) : r.new_second;
                    clk_ms = '0;
                    time_set = 1'b1;
                end
                OP_START: begin
                    remain = (r.countdown_ms > MAX_COUNTDOWN) ? MAX_COUNTDOWN : r.countdown_ms;
                    counting = 1'b1;
                    ring_pos = '0;
                end
                default: begin
                    ringing = 1'b0;
                    counting = 1'b0;
                end
            endcase

            pulse = ring_pos < RING_PULSE_MS;
            if (timer_view) begin
                total_s = remain / MS_PER_SEC;
                hh = total_s / SEC_PER_HOUR;
                mm = (total_s / SEC_PER_MIN) % SEC_PER_MIN;
                ss = total_s % SEC_PER_MIN;
                d.sound = counting && remain == '0 && pulse;
            end else begin
                hh = clk_hour;
                if (!hour_24 && clk_hour > HALF_DAY) hh = clk_hour - HALF_DAY;
                else if (!hour_24 && clk_hour == '0 && time_set) hh = HALF_DAY;
                mm = clk_min;
                ss = clk_sec;
                d.sound = ringing && pulse;
            end
            d.d0 = 4'(hh / DEC_BASE);
            d.d1 = 4'(hh % DEC_BASE);
            d.d2 = 4'(mm / DEC_BASE);
            d.d3 = 4'(mm % DEC_BASE);
            d.d4 = 4'(ss / DEC_BASE);
            d.d5 = 4'(ss % DEC_BASE);
            if (!timer_view && !lead_zero && hh < DEC_BASE && time_set) d.d0 = BLANK_DIGIT;
            d.night = !(clk_hour >= day_first && clk_hour <= day_last);
            d.millis = clk_ms;
            d.alarm = ringing;
            due_displays.push_back(d);
        endfunction

        task report(string msg);
            $display("MISMATCH display %0d: %s", displays_seen, msg);
            mismatches++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want) report($sformatf("%s got %0d, want %0d", name, got, want));
        endtask

        task check_display(t_disp got);
            t_disp want;
            displays_seen++;
            if (due_displays.size() == 0) begin
                report($sformatf("display %h with no request outstanding", got));
                return;
            end
            want = due_displays.pop_front();
            compare_field("digit0", got.d0, want.d0);
            compare_field("digit1", got.d1, want.d1);
            compare_field("digit2", got.d2, want.d2);
            compare_field("digit3", got.d3, want.d3);
            compare_field("digit4", got.d4, want.d4);
            compare_field("digit5", got.d5, want.d5);
            compare_field("night_flag", got.night, want.night);
            compare_field("millis_part", got.millis, want.millis);
            compare_field("sound", got.sound, want.sound);
            compare_field("alarm_playing", got.alarm, want.alarm);
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [5:0] cfg_data = '0;
    bit         gaps_on = 1'b1;
    int         hold_cycles = 0;
    int         quiet = 0;
    t_disp      shown;
    display_scoreboard sb;

    cacd_req_if req_if();
    cacd_res_if res_if();

    clock_alarm_countdown_display dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // result side: random stalls, plus one long hold-off on demand
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                res_if.ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            shown.d0 = res_if.digit0;
            shown.d1 = res_if.digit1;
            shown.d2 = res_if.digit2;
            shown.d3 = res_if.digit3;
            shown.d4 = res_if.digit4;
            shown.d5 = res_if.digit5;
            shown.night = res_if.night_flag;
            shown.millis = res_if.millis_part;
            shown.sound = res_if.sound;
            shown.alarm = res_if.alarm_playing;
            sb.check_display(shown);
        end
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_req random_req(t_opcode op);
        t_req r;
        r.opcode = op;
        r.new_hour = 5'($urandom);
        r.new_minute = 6'($urandom);
        r.new_second = 6'($urandom);
        r.countdown_ms = 29'($urandom);
        return r;
    endfunction

    task automatic send_request(t_req r);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.opcode <= r.opcode;
        req_if.new_hour <= r.new_hour;
        req_if.new_minute <= r.new_minute;
        req_if.new_second <= r.new_second;
        req_if.countdown_ms <= r.countdown_ms;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sb.take_request(r);
    endtask

    task automatic tick(int n);
        repeat (n) send_request(random_req(OP_TICK));
    endtask

    task automatic set_time(logic [4:0] h, logic [5:0] m, logic [5:0] s);
        t_req r;
        r = random_req(OP_SET_TIME);
        r.new_hour = h;
        r.new_minute = m;
        r.new_second = s;
        send_request(r);
    endtask

    task automatic start_countdown(logic [28:0] ms);
        t_req r;
        r = random_req(OP_START);
        r.countdown_ms = ms;
        send_request(r);
    endtask

    task automatic silence();
        send_request(random_req(OP_SILENCE));
    endtask

    // stop offering requests and wait until every display is back
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.due_displays.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [5:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic configure(logic [5:0] h24, logic [5:0] lz, logic [5:0] ah, logic [5:0] am,
                             logic [5:0] as_, logic [5:0] ds, logic [5:0] de, logic [5:0] tm);
        settle();
        write_reg(REG_HOUR_24_MODE, h24);
        write_reg(REG_SHOW_LEADING_ZERO, lz);
        write_reg(REG_ALARM_HOUR, ah);
        write_reg(REG_ALARM_MINUTE, am);
        write_reg(REG_ALARM_SECOND, as_);
        write_reg(REG_DAY_START_HOUR, ds);
        write_reg(REG_DAY_END_HOUR, de);
        write_reg(REG_SHOW_TIMER, tm);
        cfg_we <= 1'b0;
    endtask

    task automatic probe_hours();
        set_time(5'd0, 6'd0, 6'd0);
        tick(1);
        set_time(5'd9, 6'd59, 6'd59);
        set_time(5'd12, 6'd0, 6'd0);
        set_time(5'd13, 6'd0, 6'd0);
        set_time(5'd23, 6'd59, 6'd59);
    endtask

    task automatic clock_traffic(int budget);
        int sent;
        int n;
        int pick;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                set_time(sb.alarm_h, sb.alarm_m, sb.alarm_s);
                n = $urandom_range(20, 150);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 39) == 0) silence();
                    else tick(1);
                end
                n++;
            end else if (pick < 6) begin
                set_time(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                         6'($urandom_range(0, 59)));
                n = $urandom_range(1, 60);
                tick(n);
                n++;
            end else if (pick == 6) begin
                start_countdown(29'($urandom_range(0, 200)));
                n = $urandom_range(1, 300);
                tick(n);
                n++;
            end else if (pick == 7) begin
                // silence inside the alarm second restarts the alarm on the next tick
                set_time(sb.alarm_h, sb.alarm_m, sb.alarm_s);
                tick(1);
                silence();
                tick(2);
                n = 4;
            end else begin
                n = $urandom_range(1, 12);
                repeat (n) send_request(random_req(t_opcode'($urandom_range(0, 3))));
            end
            sent += n;
        end
    endtask

    task automatic timer_traffic(int budget);
        int sent;
        int n;
        int pick;
        int unsigned base;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                start_countdown(29'($urandom_range(0, 300)));
                n = $urandom_range(1, 450);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 59) == 0) silence();
                    else tick(1);
                end
                n++;
            end else if (pick < 6) begin
                case ($urandom_range(0, 4))
                    0: base = 1;
                    1: base = SEC_PER_MIN;
                    2: base = SEC_PER_HOUR;
                    3: base = 10 * SEC_PER_HOUR;
                    default: base = MAX_SECS;
                endcase
                start_countdown(29'(base * MS_PER_SEC + $urandom_range(0, 20)));
                tick(25);
                n = 26;
            end else if (pick == 6) begin
                start_countdown(29'($urandom));
                n = $urandom_range(1, 10);
                tick(n);
                n++;
            end else if (pick == 7) begin
                set_time(sb.alarm_h, sb.alarm_m, sb.alarm_s);
                n = $urandom_range(1, 20);
                tick(n);
                n++;
            end else begin
                n = $urandom_range(1, 12);
                repeat (n) send_request(random_req(t_opcode'($urandom_range(0, 3))));
            end
            sent += n;
        end
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.opcode = OP_TICK;
        req_if.new_hour = '0;
        req_if.new_minute = '0;
        req_if.new_second = '0;
        req_if.countdown_ms = '0;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, time never set
        tick(1);
        silence();
        clock_traffic(40);

        configure(6'd0, 6'd0, 6'd7, 6'd0, 6'd0, 6'd6, 6'd18, 6'd0);
        set_time(5'd0, 6'd0, 6'd0);
        tick(1);
        set_time(5'd31, 6'd63, 6'd63);
        set_time(5'd0, 6'd0, 6'd0);
        start_countdown(29'h1FFF_FFFF);
        start_countdown('0);
        tick(1);
        silence();
        set_time(5'd7, 6'd0, 6'd0);
        tick(2);
        silence();
        tick(1);
        silence();
        probe_hours();
        hold_cycles = HOLD_CYCLES;
        clock_traffic(200);

        // day rollover in 12-hour form, alarm at the last second of the day
        configure(6'd0, 6'd1, 6'd23, 6'd59, 6'd59, 6'd0, 6'd23, 6'd0);
        set_time(5'd23, 6'd59, 6'd59);
        tick(1005);
        probe_hours();
        clock_traffic(60);

        // alarm hour out of range, inverted day window
        configure(6'd1, 6'd0, 6'd31, 6'd63, 6'd63, 6'd23, 6'd0, 6'd0);
        probe_hours();
        clock_traffic(120);

        configure(6'd1, 6'd1, 6'd0, 6'd0, 6'd0, 6'd12, 6'd12, 6'd1);
        start_countdown('0);
        tick(1);
        start_countdown(29'h1FFF_FFFF);
        start_countdown(MAX_COUNTDOWN);
        silence();
        tick(1);
        timer_traffic(200);

        configure(6'd0, 6'd0, 6'd12, 6'd30, 6'd30, 6'd5, 6'd20, 6'd1);
        timer_traffic(120);

        gaps_on = 1'b0;
        configure(6'($urandom_range(0, 1)), 6'($urandom_range(0, 1)),
                  6'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                  6'($urandom_range(0, 59)), 6'($urandom_range(0, 23)),
                  6'($urandom_range(0, 23)), 6'd0);
        probe_hours();
        clock_traffic(150);

        settle();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.due_displays.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
